// ===== hdl/u8sd_pkg.sv =====
package u8sd_pkg;

  // Result status codes
  localparam logic [2:0] ST_CHAR     = 3'd0;
  localparam logic [2:0] ST_UTF16_BE = 3'd1;
  localparam logic [2:0] ST_UTF16_LE = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;

  // Held byte order marker codes
  localparam logic [1:0] HM_NONE = 2'd0;
  localparam logic [1:0] HM_FE   = 2'd1;
  localparam logic [1:0] HM_FF   = 2'd2;

  // Bytes with a special meaning
  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  localparam int unsigned CP_W = 21;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [2:0]      status;
    logic            run_last;
    logic            text_end;
  } result_t;

  // One queue entry: the one or two results caused by a single byte
  typedef struct packed {
    logic    two;
    result_t r1;
    result_t r0;
  } entry_t;

  function automatic result_t mk_res(logic [CP_W-1:0] cp, logic [2:0] st);
    result_t r;
    r.cp       = cp;
    r.status   = st;
    r.run_last = 1'b0;
    r.text_end = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/u8sd_front.sv =====
module u8sd_front
  import u8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_take,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       final_byte,
  output logic       q_push,
  output entry_t     q_entry
);

  logic [1:0]      br;
  logic [CP_W-1:0] pv;
  logic            sas;
  logic [1:0]      hm;
  logic            disc;

  logic [1:0]      br_next;
  logic [CP_W-1:0] pv_next;
  logic            sas_next;
  logic [1:0]      hm_next;
  logic            disc_next;

  logic [1:0]      c_br;
  logic [CP_W-1:0] c_pv;
  logic            c_sas;
  logic [1:0]      c_hm;
  logic            c_disc;

  logic    a_vld, b_vld, c_vld;
  result_t a_res, b_res, c_res;
  logic    utf16, skip, ended;
  logic [CP_W-1:0] byte_cp;

  assign byte_cp = {{(CP_W-8){1'b0}}, data_byte};

  // Classify the byte against the held state and build up to two results
  always_comb begin
    c_br   = first_byte ? 2'd0 : br;
    c_pv   = first_byte ? '0 : pv;
    c_sas  = first_byte ? 1'b0 : sas;
    c_hm   = first_byte ? HM_NONE : hm;
    c_disc = first_byte ? 1'b0 : disc;

    br_next   = c_br;
    pv_next   = c_pv;
    sas_next  = c_sas;
    hm_next   = HM_NONE;
    disc_next = c_disc;

    a_vld = 1'b0;
    b_vld = 1'b0;
    c_vld = 1'b0;
    a_res = mk_res('0, ST_CHAR);
    b_res = mk_res('0, ST_CHAR);
    c_res = mk_res('0, ST_CHAR);
    utf16 = 1'b0;
    skip  = 1'b0;

    if (c_disc) begin
      disc_next = ~final_byte;
    end else begin
      // resolve a held FE or FF
      case (c_hm)
        HM_FE: begin
          if (data_byte == BYTE_FF) begin
            a_vld = 1'b1;
            a_res = mk_res('0, ST_UTF16_BE);
            utf16 = 1'b1;
            skip  = 1'b1;
          end else begin
            a_vld = 1'b1;
            a_res = mk_res({{(CP_W-8){1'b0}}, BYTE_FE}, ST_CHAR);
          end
        end
        HM_FF: begin
          sas_next = 1'b0;
          if (data_byte == BYTE_FE) begin
            skip = 1'b1;
            if (c_sas) begin
              a_vld = 1'b1;
              a_res = mk_res('0, ST_UTF16_LE);
              utf16 = 1'b1;
            end
          end else begin
            a_vld = 1'b1;
            a_res = mk_res({{(CP_W-8){1'b0}}, BYTE_FF}, ST_CHAR);
          end
        end
        default: ;
      endcase

      if (utf16) begin
        br_next   = 2'd0;
        pv_next   = '0;
        sas_next  = 1'b0;
        disc_next = ~final_byte;
      end

      // decode the byte itself
      if (!skip) begin
        if (c_br != 2'd0) begin
          case (c_br)
            2'd1:    pv_next = c_pv | {{(CP_W-6){1'b0}}, data_byte[5:0]};
            2'd2:    pv_next = c_pv | {{(CP_W-12){1'b0}}, data_byte[5:0], 6'b0};
            default: pv_next = c_pv | {{(CP_W-18){1'b0}}, data_byte[5:0], 12'b0};
          endcase
          br_next = c_br - 2'd1;
          if (br_next == 2'd1 && data_byte != BYTE_BB) begin
            sas_next = 1'b0;
          end
          if (br_next == 2'd0) begin
            if (!(sas_next && data_byte == BYTE_BF)) begin
              b_vld = 1'b1;
              b_res = mk_res(pv_next, ST_CHAR);
            end
            sas_next = 1'b0;
            pv_next  = '0;
          end
        end else begin
          sas_next = 1'b0;
          if (data_byte[7] == 1'b0) begin
            b_vld = 1'b1;
            b_res = mk_res(byte_cp, ST_CHAR);
          end else if (data_byte[7:5] == 3'b110) begin
            pv_next = {{(CP_W-11){1'b0}}, data_byte[4:0], 6'b0};
            br_next = 2'd1;
          end else if (data_byte[7:4] == 4'b1110) begin
            pv_next  = {{(CP_W-16){1'b0}}, data_byte[3:0], 12'b0};
            br_next  = 2'd2;
            sas_next = first_byte && (data_byte == BYTE_EF);
          end else if (data_byte[7:3] == 5'b11110) begin
            pv_next = {data_byte[2:0], 18'b0};
            br_next = 2'd3;
          end else if (data_byte == BYTE_FE && first_byte) begin
            hm_next = HM_FE;
          end else if (data_byte == BYTE_FF) begin
            hm_next  = HM_FF;
            sas_next = first_byte;
          end else begin
            b_vld = 1'b1;
            b_res = mk_res(byte_cp, ST_CHAR);
          end
        end
      end

      // close the text on its final byte
      if (final_byte && !utf16 && !(a_vld && b_vld)) begin
        if (br_next != 2'd0) begin
          c_vld = 1'b1;
          c_res = mk_res('0, ST_TRUNC);
        end else if (hm_next == HM_FE) begin
          c_vld = 1'b1;
          c_res = mk_res({{(CP_W-8){1'b0}}, BYTE_FE}, ST_CHAR);
        end else if (hm_next == HM_FF) begin
          c_vld = 1'b1;
          c_res = mk_res({{(CP_W-8){1'b0}}, BYTE_FF}, ST_CHAR);
        end else if (!a_vld && !b_vld) begin
          c_vld = 1'b1;
          c_res = mk_res('0, ST_END);
        end
      end
    end

    if (final_byte) begin
      br_next   = 2'd0;
      pv_next   = '0;
      sas_next  = 1'b0;
      hm_next   = HM_NONE;
      disc_next = 1'b0;
    end
  end

  assign ended = final_byte | utf16;

  // Pack the results in order and flag the last one
  always_comb begin
    q_entry = '0;
    if (a_vld) begin
      q_entry.r0  = a_res;
      q_entry.two = b_vld | c_vld;
      q_entry.r1  = b_vld ? b_res : c_res;
    end else if (b_vld) begin
      q_entry.r0  = b_res;
      q_entry.two = c_vld;
      q_entry.r1  = c_res;
    end else begin
      q_entry.r0  = c_res;
      q_entry.two = 1'b0;
    end
    if (q_entry.two) begin
      q_entry.r1.run_last = 1'b1;
      q_entry.r1.text_end = ended;
    end else begin
      q_entry.r0.run_last = 1'b1;
      q_entry.r0.text_end = ended;
    end
  end

  assign q_push = in_take & (a_vld | b_vld | c_vld);

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      br   <= 2'd0;
      pv   <= '0;
      sas  <= 1'b0;
      hm   <= HM_NONE;
      disc <= 1'b0;
    end else if (in_take) begin
      br   <= br_next;
      pv   <= pv_next;
      sas  <= sas_next;
      hm   <= hm_next;
      disc <= disc_next;
    end
  end

endmodule

// ===== hdl/u8sd_queue.sv =====
module u8sd_queue
  import u8sd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   rd,
  output entry_t rd_entry,
  output logic   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_wr;
  logic             do_rd;

  assign full     = (cnt == CNT_W'(DEPTH));
  assign empty    = (cnt == '0);
  assign do_wr    = wr & ~full;
  assign do_rd    = rd & ~empty;
  assign rd_entry = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/u8sd_back.sv =====
module u8sd_back
  import u8sd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  entry_t          head,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [CP_W-1:0] code_point,
  output logic [2:0]      status,
  output logic            run_last,
  output logic            text_end
);

  logic    slot;
  logic    take;
  result_t cur;

  assign empty = q_empty;
  assign take  = pop & ~q_empty;
  assign cur   = slot ? head.r1 : head.r0;
  assign q_pop = take & (slot | ~head.two);

  assign code_point = cur.cp;
  assign status     = cur.status;
  assign run_last   = cur.run_last;
  assign text_end   = cur.text_end;

  // Step through the one or two results of the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 1'b0;
    end else if (take) begin
      slot <= ~slot & head.two;
    end
  end

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// Streaming UTF-8 decoder. Bytes enter as queue beats (push/full) with flags for the first
// and last byte of a text; decoded code points leave as queue beats (empty/pop). One byte
// is accepted per clock whenever the internal result queue has room, and one result leaves
// per clock when pop is held and empty is low; a byte gives zero, one or two results, each
// leaving on its own pop. The front classifies each byte and updates the decoder state in
// the cycle it is taken; its results go into a queue of QUEUE_DEPTH entries (one entry per
// byte with results), which sets how long the output side may stall before full rises.
// A result is registered in the queue before it reaches the output ports. Status is 0 for a
// character, 1 or 2 for a UTF-16 byte order mark (the rest of that text is then dropped),
// 3 for a sequence cut off by the last byte, 4 for a text end that carries no character.
module utf8_stream_decoder
  import u8sd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      data_byte,
  input  logic            first_byte,
  input  logic            final_byte,
  output logic            empty,
  input  logic            pop,
  output logic [CP_W-1:0] code_point,
  output logic [2:0]      status,
  output logic            run_last,
  output logic            text_end
);

  logic   in_take;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  entry_t q_head;
  logic   q_empty;

  assign in_take = push & ~full;

  u8sd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_take    (in_take),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .final_byte (final_byte),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_entry (q_entry),
    .full     (full),
    .rd       (q_pop),
    .rd_entry (q_head),
    .empty    (q_empty)
  );

  u8sd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .code_point (code_point),
    .status     (status),
    .run_last   (run_last),
    .text_end   (text_end)
  );

endmodule
